>>> sv/base32_stream_decoder_core_assert.svh
// Assertion macros shared by the base32 decoder modules.
`ifndef BASE32_STREAM_DECODER_CORE_ASSERT_SVH
`define BASE32_STREAM_DECODER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define B32D_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define B32D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/b32d_pkg.sv
// Types and constants shared by the base32 decoder modules.
package b32d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // Command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_DIGIT   = 2'd0,
    CMD_INVALID = 2'd1,
    CMD_END     = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] digit;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
  } res_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_O  = 8'h4F;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [4:0] LOW5      = 5'h1F;
  localparam logic [4:0] DIGIT_OFS = 5'd8;   // '2'..'7' low bits plus this give 26..31

  localparam logic [7:0] MAX_BYTES_RESET = 8'd255;

endpackage

>>> sv/b32d_front.sv
// Front end: accepts characters, classifies them and queues commands.
module b32d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     char_in,
  output logic           cmd_valid,
  output b32d_pkg::cmd_t cmd,
  input  logic           cmd_pop
);

  b32d_pkg::cmd_t cls;
  logic           skip;
  logic [7:0]     ch;
  logic           enq;
  logic           deq;

  b32d_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  // Fold look-alike digits onto their letters
  always_comb begin
    case (char_in)
      b32d_pkg::CH_ZERO:  ch = b32d_pkg::CH_UP_O;
      b32d_pkg::CH_ONE:   ch = b32d_pkg::CH_UP_L;
      b32d_pkg::CH_EIGHT: ch = b32d_pkg::CH_UP_B;
      default:            ch = char_in;
    endcase
  end

  // Classify the character
  always_comb begin
    skip      = 1'b0;
    cls.kind  = b32d_pkg::CMD_INVALID;
    cls.digit = '0;
    if (char_in == b32d_pkg::CH_NUL) begin
      cls.kind = b32d_pkg::CMD_END;
    end else if (char_in inside {b32d_pkg::CH_SPACE, b32d_pkg::CH_TAB, b32d_pkg::CH_CR,
                                 b32d_pkg::CH_LF, b32d_pkg::CH_DASH}) begin
      skip = 1'b1;
    end else if (ch inside {[b32d_pkg::CH_UP_A : b32d_pkg::CH_UP_Z],
                            [b32d_pkg::CH_LO_A : b32d_pkg::CH_LO_Z]}) begin
      cls.kind  = b32d_pkg::CMD_DIGIT;
      cls.digit = (ch[4:0] & b32d_pkg::LOW5) - 5'd1;
    end else if (ch inside {[b32d_pkg::CH_TWO : b32d_pkg::CH_SEVEN]}) begin
      cls.kind  = b32d_pkg::CMD_DIGIT;
      cls.digit = ch[4:0] + b32d_pkg::DIGIT_OFS;
    end
  end

  assign full      = (count == 2'd2);
  assign enq       = push && !full && !skip;
  assign cmd_valid = (count != 2'd0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q[rd_ptr];

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

>>> sv/b32d_back.sv
// Back end: runs decode commands against the bit buffer and queues results.
`include "base32_stream_decoder_core_assert.svh"

module b32d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_data,
  input  logic           cmd_valid,
  input  b32d_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output b32d_pkg::res_t res
);

  logic [7:0]  max_bytes;
  logic [11:0] bit_buffer;
  logic [11:0] bit_buffer_next;
  logic [2:0]  bits_pending;
  logic [2:0]  bits_pending_next;
  logic [7:0]  bytes_emitted;
  logic [7:0]  bytes_emitted_next;
  logic        error_seen;
  logic        error_seen_next;

  logic [11:0] buf_shift;
  logic [3:0]  pend_sum;
  logic [3:0]  shamt;
  logic [11:0] aligned;

  logic             res_push;
  b32d_pkg::res_t   res_in;
  b32d_pkg::res_t   rq [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       res_count;
  logic             res_full;
  logic             res_pop;

  assign res_full = (res_count == 2'd2);
  assign cmd_pop  = cmd_valid && !res_full;

  // Shift the new digit in and line up the oldest eight bits
  assign buf_shift = {bit_buffer[6:0], cmd.digit};
  assign pend_sum  = {1'b0, bits_pending} + 4'd5;
  assign shamt     = pend_sum - 4'd8;
  assign aligned   = buf_shift >> shamt;

  // Execute one command
  always_comb begin
    bit_buffer_next    = bit_buffer;
    bits_pending_next  = bits_pending;
    bytes_emitted_next = bytes_emitted;
    error_seen_next    = error_seen;
    res_push           = 1'b0;
    res_in.status      = b32d_pkg::ST_DATA;
    res_in.data_byte   = '0;
    res_in.byte_count  = bytes_emitted;
    if (cmd_pop) begin
      if (cmd.kind == b32d_pkg::CMD_END) begin
        res_push           = 1'b1;
        res_in.status      = b32d_pkg::ST_DONE;
        bit_buffer_next    = '0;
        bits_pending_next  = '0;
        bytes_emitted_next = '0;
        error_seen_next    = 1'b0;
      end else if (!error_seen && (bytes_emitted < max_bytes)) begin
        if (cmd.kind == b32d_pkg::CMD_INVALID) begin
          res_push        = 1'b1;
          res_in.status   = b32d_pkg::ST_ERROR;
          error_seen_next = 1'b1;
        end else begin
          bit_buffer_next = buf_shift;
          if (pend_sum >= 4'd8) begin
            bits_pending_next  = shamt[2:0];
            bytes_emitted_next = bytes_emitted + 8'd1;
            res_push           = 1'b1;
            res_in.data_byte   = aligned[7:0];
            res_in.byte_count  = bytes_emitted + 8'd1;
          end else begin
            bits_pending_next = pend_sum[2:0];
          end
        end
      end
    end
  end

  // Hold decode state and the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes     <= b32d_pkg::MAX_BYTES_RESET;
      bit_buffer    <= '0;
      bits_pending  <= '0;
      bytes_emitted <= '0;
      error_seen    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_bytes <= cfg_data;
      end
      bit_buffer    <= bit_buffer_next;
      bits_pending  <= bits_pending_next;
      bytes_emitted <= bytes_emitted_next;
      error_seen    <= error_seen_next;
    end
  end

  // Result queue
  assign empty   = (res_count == 2'd0);
  assign res_pop = pop && !empty;
  assign res     = rq[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (res_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      res_count <= res_count + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  `B32D_ASSERT_NOW(a_res_count_bound, clk, rst, 1'b1, res_count <= 2'd2)
  `B32D_ASSERT_NOW(a_no_push_when_full, clk, rst, res_full, !res_push)
  `B32D_ASSERT_NEXT(a_end_clears, clk, rst, cmd_pop && (cmd.kind == b32d_pkg::CMD_END),
                    (bytes_emitted == 8'd0) && (bits_pending == 3'd0) && !error_seen)
  `B32D_ASSERT_NOW(a_quiet_after_error, clk, rst,
                   error_seen && cmd_pop && (cmd.kind != b32d_pkg::CMD_END), !res_push)
  `B32D_ASSERT_NEXT(a_data_counts, clk, rst, res_push && (res_in.status == b32d_pkg::ST_DATA),
                    bytes_emitted == $past(res_in.byte_count))

endmodule

>>> sv/base32_stream_decoder_core.sv
// Top level of the base32 stream decoder: front classifier, command queue, decode back end.
//
// Decodes an RFC 4648 base32 character stream, one character per word on push/full,
// at a sustained rate of one character per clock cycle while full is low; a zero character
// ends the string. Blanks and '-' are dropped by the front classifier, which feeds a
// two-entry command queue; the back end updates the bit buffer and emits data, done and
// error results into a two-entry result queue read with empty/pop. An accepted character
// is registered into the command queue, and its result is then registered into the
// result queue, from which it shows on the result ports. The byte limit max_bytes (reset 255)
// is written through cfg_we/cfg_data and should only change while the decoder is idle.
module base32_stream_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic [7:0] data_byte,
  output logic [7:0] byte_count,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  logic           cmd_valid;
  logic           cmd_pop;
  b32d_pkg::cmd_t cmd;
  b32d_pkg::res_t res;

  b32d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .char_in   (char_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  b32d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  // Unpack the head result
  assign status     = 2'(res.status);
  assign data_byte  = res.data_byte;
  assign byte_count = res.byte_count;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the base32 stream decoder core.
module tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int TARGET_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;

  // Track decoder state per accepted character and check each output word
  class decode_tracker;
    b32d_pkg::res_t pending_words[$];
    logic [7:0]     byte_limit;
    logic [11:0]    bit_buf;
    logic [2:0]     fill_bits;
    logic [7:0]     emitted;
    bit             in_error;
    int             fails;
    int             chars;
    int             strings;
    int             n_data;
    int             n_done;
    int             n_error;

    function new();
      byte_limit = b32d_pkg::MAX_BYTES_RESET;
      clear_string();
      fails   = 0;
      chars   = 0;
      strings = 0;
      n_data  = 0;
      n_done  = 0;
      n_error = 0;
    endfunction

    function void clear_string();
      bit_buf   = '0;
      fill_bits = '0;
      emitted   = '0;
      in_error  = 1'b0;
    endfunction

    function void set_limit(logic [7:0] v);
      byte_limit = v;
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == b32d_pkg::CH_SPACE || c == b32d_pkg::CH_TAB || c == b32d_pkg::CH_CR ||
             c == b32d_pkg::CH_LF || c == b32d_pkg::CH_DASH;
    endfunction

    // Map a character to its 5-bit value; 0, 1 and 8 stand for O, L and B
    static function bit decode_digit(input logic [7:0] c, output logic [4:0] d);
      logic [7:0] m;
      m = c;
      if (c == b32d_pkg::CH_ZERO) m = b32d_pkg::CH_UP_O;
      else if (c == b32d_pkg::CH_ONE) m = b32d_pkg::CH_UP_L;
      else if (c == b32d_pkg::CH_EIGHT) m = b32d_pkg::CH_UP_B;
      d = '0;
      if ((m >= b32d_pkg::CH_UP_A && m <= b32d_pkg::CH_UP_Z) ||
          (m >= b32d_pkg::CH_LO_A && m <= b32d_pkg::CH_LO_Z)) begin
        d = m[4:0] - 5'd1;
        return 1'b1;
      end
      if (m >= b32d_pkg::CH_TWO && m <= b32d_pkg::CH_SEVEN) begin
        d = 5'(m - b32d_pkg::CH_TWO) + 5'd26;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Advance the decode state; return 1 when the character was not ignored
    function bit note_char(logic [7:0] c);
      logic [4:0]     d;
      logic [3:0]     fill;
      b32d_pkg::res_t w;
      chars++;
      if (c == b32d_pkg::CH_NUL) begin
        w.status     = b32d_pkg::ST_DONE;
        w.data_byte  = 8'd0;
        w.byte_count = emitted;
        pending_words.push_back(w);
        strings++;
        clear_string();
        return 1'b1;
      end
      if (in_error || emitted >= byte_limit) return 1'b0;
      if (is_blank(c)) return 1'b0;
      if (!decode_digit(c, d)) begin
        in_error     = 1'b1;
        w.status     = b32d_pkg::ST_ERROR;
        w.data_byte  = 8'd0;
        w.byte_count = emitted;
        pending_words.push_back(w);
        return 1'b1;
      end
      bit_buf = {bit_buf[6:0], d};
      fill    = {1'b0, fill_bits} + 4'd5;
      if (fill >= 4'd8) begin
        emitted      = emitted + 8'd1;
        w.status     = b32d_pkg::ST_DATA;
        w.data_byte  = 8'(bit_buf >> (fill - 4'd8));
        w.byte_count = emitted;
        pending_words.push_back(w);
        fill_bits = 3'(fill - 4'd8);
      end else begin
        fill_bits = fill[2:0];
      end
      return 1'b1;
    endfunction

    // Compare one popped word with the oldest expected word
    function void check_word(b32d_pkg::status_t st, logic [7:0] db, logic [7:0] bc);
      b32d_pkg::res_t w;
      if (pending_words.size() == 0) begin
        $display("%0t: expected no word, actual status %0d data %0h count %0d",
                 $time, st, db, bc);
        fails++;
        return;
      end
      w = pending_words.pop_front();
      if (st != w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, st);
        fails++;
      end
      if (db != w.data_byte) begin
        $display("%0t: data_byte expected %0h actual %0h", $time, w.data_byte, db);
        fails++;
      end
      if (bc != w.byte_count) begin
        $display("%0t: byte_count expected %0d actual %0d", $time, w.byte_count, bc);
        fails++;
      end
      case (w.status)
        b32d_pkg::ST_DATA: n_data++;
        b32d_pkg::ST_DONE: n_done++;
        default: n_error++;
      endcase
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] char_in;
  logic       empty;
  logic       pop;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic [7:0] byte_count;
  logic       cfg_we;
  logic [7:0] cfg_data;

  decode_tracker tracker = new();
  int  cycles = 0;
  int  sent_items = 0;
  int  burst_left = 0;
  int  limit_settings = 0;
  bit  hold_req = 1'b0;
  logic [7:0] blanks[5] = '{b32d_pkg::CH_SPACE, b32d_pkg::CH_TAB, b32d_pkg::CH_CR,
                            b32d_pkg::CH_LF, b32d_pkg::CH_DASH};

  base32_stream_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_in    (char_in),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .data_byte  (data_byte),
    .byte_count (byte_count),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one character, opening a new burst after a random gap when due
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    push    <= 1'b1;
    char_in <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    void'(tracker.note_char(c));
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(b32d_pkg::CH_NUL);
  endtask

  // Drain all words and let skipped characters clear the pipe, then write the limit
  task automatic write_limit(input logic [7:0] v);
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    tracker.set_limit(v);
    cfg_we <= 1'b0;
    limit_settings++;
  endtask

  function automatic logic [7:0] pick_digit_char();
    int v;
    int r;
    v = $urandom_range(0, 31);
    r = $urandom_range(0, 9);
    if (v >= 26) return b32d_pkg::CH_TWO + 8'(v - 26);
    if (r < 3 && v == 14) return b32d_pkg::CH_ZERO;
    if (r < 3 && v == 11) return b32d_pkg::CH_ONE;
    if (r < 3 && v == 1) return b32d_pkg::CH_EIGHT;
    return (r[0] ? b32d_pkg::CH_LO_A : b32d_pkg::CH_UP_A) + 8'(v);
  endfunction

  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (decode_tracker::is_blank(c) || decode_tracker::decode_digit(c, d));
    return c;
  endfunction

  // Send one string; mostly well-formed, some with a bad character, some raw noise
  task automatic send_random_string(input int force_len);
    int kind;
    int len;
    int bad_at;
    kind   = (force_len > 0) ? 0 : $urandom_range(0, 19);
    len    = (force_len > 0) ? force_len :
             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 16);
    bad_at = (kind >= 14 && kind <= 16) ? $urandom_range(0, len) : -1;
    if (kind == 19) len = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if (kind == 17 || kind == 18) begin
        send_char(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 7) == 0) send_char(blanks[$urandom_range(0, 4)]);
        if (i == bad_at) send_char(pick_bad_char());
        send_char(pick_digit_char());
      end
    end
    send_char(b32d_pkg::CH_NUL);
  endtask

  // Receiver: check popped words, stall on a changing mask, hold off once on request
  initial begin
    logic [15:0] stall_mask;
    int          r;
    pop = 1'b0;
    stall_mask = '1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        tracker.check_word(b32d_pkg::status_t'(status), data_byte, byte_count);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (cycles % 64 == 0) begin
        r = $urandom_range(0, 3);
        case (r)
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom);
          2: stall_mask = 16'($urandom | $urandom);
          default: stall_mask = 16'($urandom & $urandom);
        endcase
      end
      pop <= stall_mask[cycles % 16];
    end
  end

  // Stimulus
  initial begin
    logic [7:0] limits[8];
    logic [7:0] lim;
    int         phase_items;
    int         phase_strings;
    bit         long_done;
    limits   = '{8'd1, 8'd9, 8'd255, 8'd2, 8'd40, 8'd0, 8'd255, 8'd128};
    rst      = 1'b1;
    push     = 1'b0;
    char_in  = b32d_pkg::CH_NUL;
    cfg_we   = 1'b0;
    cfg_data = 8'd0;
    long_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: letter and digit extremes, aliases, blanks, errors, empty string, limit
    send_text("Az27 \t\r\n-018aZ");
    send_text("M9Q");
    send_text("");
    write_limit(8'd1);
    send_text("ABC!");

    // Random phases, each opened by writing a byte limit
    for (int p = 0; sent_items < TARGET_ITEMS; p++) begin
      lim = (p < 8) ? limits[p] : 8'($urandom_range(1, 255));
      write_limit(lim);
      if (p == 1) hold_req = 1'b1;
      phase_items   = sent_items;
      phase_strings = 0;
      while (sent_items - phase_items < 120 && phase_strings < 40 &&
             sent_items < TARGET_ITEMS) begin
        if (lim == 8'd255 && !long_done) begin
          send_random_string(420);
          long_done = 1'b1;
        end else begin
          send_random_string(0);
        end
        phase_strings++;
      end
    end

    // Drain and finish
    push <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d strings, %0d characters under %0d byte limits",
             tracker.strings, tracker.chars, limit_settings);
    $display("checked %0d data, %0d done and %0d error words",
             tracker.n_data, tracker.n_done, tracker.n_error);
    if (tracker.fails == 0 && tracker.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/b32d_pkg.sv
sv/b32d_front.sv
sv/b32d_back.sv
sv/base32_stream_decoder_core.sv
dv/tb.sv
